[sv/icmp_chk_pkg.sv]
`default_nettype none

package icmp_chk_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [WORD_W-1:0] HEADER_LEN   = 16'd8;
    localparam logic [WORD_W-1:0] SUM_ALL_ONES = 16'hFFFF;
    localparam logic [WORD_W-1:0] COUNT_MAX    = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_MATCH_IDENT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_SEQ   = 8'd1;

    localparam logic [2:0] POS_TYPE     = 3'd0;
    localparam logic [2:0] POS_CODE     = 3'd1;
    localparam logic [2:0] POS_ID_HI    = 3'd4;
    localparam logic [2:0] POS_ID_LO    = 3'd5;
    localparam logic [2:0] POS_SEQ_HI   = 3'd6;
    localparam logic [2:0] POS_SEQ_LO   = 3'd7;

    typedef struct packed {
        logic [WORD_W-1:0] match_ident;
        logic [WORD_W-1:0] match_seq;
    } cfg_t;

    typedef struct packed {
        logic              accepted;
        logic [WORD_W-1:0] payload_len;
    } result_t;

    function automatic logic [WORD_W-1:0] add_ones(input logic [WORD_W-1:0] a,
                                                    input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
    endfunction

endpackage

`default_nettype wire

[sv/icmp_chk_cfg.sv]
`default_nettype none

module icmp_chk_cfg (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_fire,
    input  wire logic [icmp_chk_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [icmp_chk_pkg::CFG_DATA_W-1:0] cfg_data,
    output icmp_chk_pkg::cfg_t                       cfg
);

    icmp_chk_pkg::cfg_t cfg_reg;
    icmp_chk_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_fire) begin
            if (cfg_index == icmp_chk_pkg::REG_MATCH_IDENT) begin
                cfg_next.match_ident = cfg_data;
            end else if (cfg_index == icmp_chk_pkg::REG_MATCH_SEQ) begin
                cfg_next.match_seq = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

    a_unknown_index_ignored: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_fire && cfg_index != icmp_chk_pkg::REG_MATCH_IDENT
        && cfg_index != icmp_chk_pkg::REG_MATCH_SEQ |=> $stable(cfg_reg))
        else $error("Write to an unknown register changed the configuration.");

endmodule

`default_nettype wire

[sv/icmp_chk_core.sv]
`default_nettype none

module icmp_chk_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            in_fire,
    input  wire logic [icmp_chk_pkg::BYTE_W-1:0] msg_byte,
    input  wire logic                            is_final,
    input  wire icmp_chk_pkg::cfg_t              cfg,
    output logic                                 res_valid,
    output icmp_chk_pkg::result_t                res
);

    logic [icmp_chk_pkg::WORD_W-1:0] byte_count_reg, byte_count_next;
    logic                            count_overflow_reg, count_overflow_next;
    logic [icmp_chk_pkg::WORD_W-1:0] ones_sum_reg, ones_sum_next;
    logic                            header_match_reg, header_match_next;
    logic [icmp_chk_pkg::WORD_W-1:0] addend;
    logic [icmp_chk_pkg::BYTE_W-1:0] want;
    logic                            ok;

    assign addend = byte_count_reg[0] ? {8'h00, msg_byte} : {msg_byte, 8'h00};

    always_comb begin
        unique case (byte_count_reg[2:0])
            icmp_chk_pkg::POS_TYPE:   want = '0;
            icmp_chk_pkg::POS_CODE:   want = '0;
            icmp_chk_pkg::POS_ID_HI:  want = cfg.match_ident[15:8];
            icmp_chk_pkg::POS_ID_LO:  want = cfg.match_ident[7:0];
            icmp_chk_pkg::POS_SEQ_HI: want = cfg.match_seq[15:8];
            icmp_chk_pkg::POS_SEQ_LO: want = cfg.match_seq[7:0];
            default:                  want = msg_byte;
        endcase
    end

    always_comb begin
        ones_sum_next       = icmp_chk_pkg::add_ones(ones_sum_reg, addend);
        header_match_next   = header_match_reg;
        byte_count_next     = byte_count_reg;
        count_overflow_next = count_overflow_reg;
        if (!count_overflow_reg && byte_count_reg < icmp_chk_pkg::HEADER_LEN
            && msg_byte != want) begin
            header_match_next = 1'b0;
        end
        if (byte_count_reg == icmp_chk_pkg::COUNT_MAX) begin
            count_overflow_next = 1'b1;
        end else begin
            byte_count_next = byte_count_reg + 16'd1;
        end
    end

    assign ok = !count_overflow_next && byte_count_next >= icmp_chk_pkg::HEADER_LEN
                && header_match_next && ones_sum_next == icmp_chk_pkg::SUM_ALL_ONES;

    assign res_valid       = in_fire && is_final;
    assign res.accepted    = ok;
    assign res.payload_len = ok ? byte_count_next - icmp_chk_pkg::HEADER_LEN : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg     <= '0;
            count_overflow_reg <= 1'b0;
            ones_sum_reg       <= '0;
            header_match_reg   <= 1'b1;
        end else if (in_fire) begin
            if (is_final) begin
                byte_count_reg     <= '0;
                count_overflow_reg <= 1'b0;
                ones_sum_reg       <= '0;
                header_match_reg   <= 1'b1;
            end else begin
                byte_count_reg     <= byte_count_next;
                count_overflow_reg <= count_overflow_next;
                ones_sum_reg       <= ones_sum_next;
                header_match_reg   <= header_match_next;
            end
        end
    end

    a_clear_after_final: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && is_final |=> byte_count_reg == '0 && ones_sum_reg == '0
        && header_match_reg && !count_overflow_reg)
        else $error("Message state was not cleared after the final byte.");

    a_overflow_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        count_overflow_reg |-> byte_count_reg == icmp_chk_pkg::COUNT_MAX)
        else $error("Overflow flag set without a saturated byte count.");

    a_reject_short: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && byte_count_reg < 16'd7 |-> !res.accepted)
        else $error("A message shorter than the header was accepted.");

endmodule

`default_nettype wire

[sv/icmp_chk_out.sv]
`default_nettype none

module icmp_chk_out (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            res_valid,
    input  wire icmp_chk_pkg::result_t           res,
    output logic                                 in_ready,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [icmp_chk_pkg::WORD_W-1:0]      m_tdata,
    output logic [0:0]                           m_tuser
);

    logic                  valid_reg, valid_next;
    icmp_chk_pkg::result_t data_reg;

    assign in_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && res_valid) begin
            data_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg.payload_len;
    assign m_tuser  = data_reg.accepted;

    a_rejected_has_no_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("Rejected result carries a nonzero payload length.");

    a_payload_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata <= 16'd65527)
        else $error("Payload length exceeds the largest possible value.");

endmodule

`default_nettype wire

[sv/icmp_echo_reply_checker.sv]
`default_nettype none

// Channel  Direction  Handshake           Payload
// s_       in         s_tvalid/s_tready   s_tdata = msg_byte, s_tlast = is_final
// m_       out        m_tvalid/m_tready   m_tdata = payload_len, m_tuser = accepted
// cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One byte is taken per cycle while s_tready is high; the result of a final byte appears in the cycle after it.
// The sum, count and header check update in the transfer cycle itself.
// A single output register holds the result; input stalls only while it is full
// and not taken. Reset is synchronous and active low; cfg_ready is always high.

module icmp_echo_reply_checker (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,   // [7:0] msg_byte
    input  wire logic                                s_tlast,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [15:0]                              m_tdata,   // [15:0] payload_len
    output logic [0:0]                               m_tuser,   // [0] accepted
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [icmp_chk_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [icmp_chk_pkg::CFG_DATA_W-1:0] cfg_data
);

    icmp_chk_pkg::cfg_t    cfg;
    icmp_chk_pkg::result_t res;
    logic                  res_valid;
    logic                  in_ready;

    assign cfg_ready = 1'b1;
    assign s_tready  = in_ready;

    icmp_chk_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_fire  (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    icmp_chk_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (s_tvalid && in_ready),
        .msg_byte  (s_tdata),
        .is_final  (s_tlast),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    icmp_chk_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .in_ready  (in_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire
